### hw/rtl/tws_pkg.sv
// Shared types, codes and sizes of the timer wheel scheduler.
package tws_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int TIME_BITS = 48;
  localparam int SLOT_BITS = $clog2(TIMER_SLOTS);
  localparam int CNT_BITS = $clog2(TIMER_SLOTS + 1);
  localparam int DIV_STEP_BITS = $clog2(TIME_BITS + 1);
  localparam int FIELD_TIME_BITS = 48;
  localparam int ID_BITS = 5;
  localparam int TAG_BITS = 16;
  localparam int CTX_BITS = 32;
  localparam int COUNT_BITS = 6;

  typedef enum logic [1:0] {
    CMD_SCHEDULE   = 2'd0,
    CMD_CANCEL_ID  = 2'd1,
    CMD_CANCEL_TAG = 2'd2,
    CMD_EXPIRE     = 2'd3
  } tws_cmd_t;

  typedef enum logic [2:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_CANCELLED = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_FULL      = 3'd5
  } tws_kind_t;

  // One timer record as held in the slot memory
  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] period;
    logic [TAG_BITS-1:0]  tag;
    logic [CTX_BITS-1:0]  ctx;
  } tws_rec_t;

  // Write request into the slot memory
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    tws_rec_t             data;
  } tws_wr_t;

  // One result word
  typedef struct packed {
    tws_kind_t             kind;
    logic [ID_BITS-1:0]    id;
    logic [TAG_BITS-1:0]   tag;
    logic [CTX_BITS-1:0]   ctx;
    logic [COUNT_BITS-1:0] count;
    logic                  notify;
    logic                  last;
  } tws_res_t;

endpackage

### hw/rtl/tws_store.sv
// Slot record memory: one write port, one registered read port.
module tws_store (
  input  logic                          clk,
  input  tws_pkg::tws_wr_t              wr,
  input  logic [tws_pkg::SLOT_BITS-1:0] rd_addr,
  output tws_pkg::tws_rec_t             rd_data
);

  tws_pkg::tws_rec_t mem [tws_pkg::TIMER_SLOTS];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/tws_div.sv
// Bit-serial remainder unit: one quotient bit per cycle.
module tws_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tws_pkg::TIME_BITS-1:0] dividend,
  input  logic [tws_pkg::TIME_BITS-1:0] divisor,
  output logic                          done,
  output logic [tws_pkg::TIME_BITS-1:0] rem
);

  logic                              run;
  logic [tws_pkg::DIV_STEP_BITS-1:0] steps;
  logic [tws_pkg::TIME_BITS-1:0]     dvd;
  logic [tws_pkg::TIME_BITS-1:0]     dvs;
  logic [tws_pkg::TIME_BITS:0]       trial;
  logic [tws_pkg::TIME_BITS:0]       trial_sub;
  logic                              fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, dvd[tws_pkg::TIME_BITS-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && (steps == tws_pkg::DIV_STEP_BITS'(1))) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      steps <= tws_pkg::DIV_STEP_BITS'(tws_pkg::TIME_BITS);
      rem   <= '0;
      dvd   <= dividend;
      dvs   <= divisor;
    end else if (run) begin
      rem   <= fits ? trial_sub[tws_pkg::TIME_BITS-1:0] : trial[tws_pkg::TIME_BITS-1:0];
      dvd   <= {dvd[tws_pkg::TIME_BITS-2:0], 1'b0};
      steps <= steps - tws_pkg::DIV_STEP_BITS'(1);
    end
  end

endmodule

### hw/rtl/timer_wheel_scheduler.sv
// Timer store top level: command sequencer around the slot memory.
//
// Holds up to TIMER_SLOTS timers in a record memory with one write port and
// one registered read port, with active flags in flip-flops, so no clearing
// pass runs after reset. Schedule writes its record on the accepting edge and
// goes straight to its result word, cancel by id of an active timer first
// reads its record, and cancel by tag scans every slot. Expire scans every
// slot once per fired timer (a periodic timer also passes through the
// bit-serial remainder unit) and once more to close with the done word. The
// one read port of the record memory and the remainder unit set how long
// these steps take. A new command is taken once the last word of the previous
// one sits in the output register, even while that word waits to be taken.
module timer_wheel_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [47:0] time_value,
  input  logic [47:0] period,
  input  logic [15:0] tag,
  input  logic [31:0] context_req,
  input  logic [4:0]  cancel_id,
  input  logic        suppress_notify,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [4:0]  id_out,
  output logic [15:0] tag_out,
  output logic [31:0] context_out,
  output logic [5:0]  count,
  output logic        notify_cancel,
  output logic        last
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CAN_RD   = 7'b0000010,
    S_TAG_SCAN = 7'b0000100,
    S_EXP_SCAN = 7'b0001000,
    S_EXP_DIV  = 7'b0010000,
    S_EXP_WR   = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t                             state;
  logic [tws_pkg::TIMER_SLOTS-1:0]    active;
  logic [tws_pkg::TIMER_SLOTS-1:0]    fired;
  logic [tws_pkg::TIME_BITS-1:0]      req_tv;
  logic [tws_pkg::TAG_BITS-1:0]       req_tag;
  logic                               req_notify;
  logic [tws_pkg::SLOT_BITS-1:0]      req_id;
  logic [tws_pkg::SLOT_BITS:0]        scan_idx;
  logic                               pv;
  logic [tws_pkg::SLOT_BITS-1:0]      pidx;
  logic [tws_pkg::CNT_BITS-1:0]       hits;
  logic                               found;
  logic [tws_pkg::SLOT_BITS-1:0]      best_idx;
  tws_pkg::tws_rec_t                  best_rec;
  logic [tws_pkg::CNT_BITS-1:0]       exp_k;
  logic [tws_pkg::TIME_BITS-1:0]      base;
  tws_pkg::tws_res_t                  res;
  tws_pkg::tws_res_t                  out_reg;

  logic                               accept;
  tws_pkg::tws_cmd_t                  cmd;
  logic [tws_pkg::TIME_BITS-1:0]      in_tv;
  logic [tws_pkg::TIME_BITS-1:0]      in_per;
  logic                               free_found;
  logic [tws_pkg::SLOT_BITS-1:0]      free_idx;
  logic                               id_ok;
  logic [tws_pkg::SLOT_BITS-1:0]      rd_addr;
  tws_pkg::tws_rec_t                  rd_data;
  tws_pkg::tws_wr_t                   wr;
  logic                               scan_done;
  logic                               scan_restart;
  logic                               cand;
  logic                               out_free;
  logic                               div_start;
  logic                               div_done;
  logic [tws_pkg::TIME_BITS-1:0]      div_rem;
  logic [tws_pkg::TIME_BITS:0]        next_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign cmd      = tws_pkg::tws_cmd_t'(command);
  assign in_tv    = tws_pkg::TIME_BITS'(time_value);
  assign in_per   = tws_pkg::TIME_BITS'(period);
  assign out_free = !out_valid || out_ready;
  assign id_ok    = (32'(cancel_id) < tws_pkg::TIMER_SLOTS) &&
                    active[cancel_id[tws_pkg::SLOT_BITS-1:0]];

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tws_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = tws_pkg::SLOT_BITS'(i);
      end
    end
  end

  // Scan pipeline status and expire candidate test
  always_comb begin
    scan_done    = (scan_idx == (tws_pkg::SLOT_BITS + 1)'(tws_pkg::TIMER_SLOTS)) && !pv;
    scan_restart = accept || ((state == S_EMIT) && out_free && !res.last);
    cand         = pv && active[pidx] && !fired[pidx] && (rd_data.deadline <= req_tv) &&
                   (!found || (rd_data.deadline < best_rec.deadline));
    rd_addr      = (state == S_IDLE) ? cancel_id[tws_pkg::SLOT_BITS-1:0]
                                     : scan_idx[tws_pkg::SLOT_BITS-1:0];
    next_sum     = {1'b0, base} + {1'b0, best_rec.period};
    div_start    = (state == S_EXP_SCAN) && scan_done && found && (best_rec.period != '0);
  end

  // Memory write: new timer on schedule, advanced deadline on expire
  always_comb begin
    wr = '0;
    if (accept && (cmd == tws_pkg::CMD_SCHEDULE) && free_found) begin
      wr.en   = 1'b1;
      wr.addr = free_idx;
      wr.data = '{deadline: in_tv, period: in_per, tag: tag, ctx: context_req};
    end else if ((state == S_EXP_WR) && !next_sum[tws_pkg::TIME_BITS]) begin
      wr.en            = 1'b1;
      wr.addr          = best_idx;
      wr.data          = best_rec;
      wr.data.deadline = next_sum[tws_pkg::TIME_BITS-1:0];
    end
  end

  tws_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_tv - best_rec.deadline),
    .divisor  (best_rec.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      active   <= '0;
      fired    <= '0;
      pv       <= 1'b0;
      scan_idx <= (tws_pkg::SLOT_BITS + 1)'(tws_pkg::TIMER_SLOTS);
    end else begin
      // Restart or advance the slot scan
      if (scan_restart) begin
        scan_idx <= '0;
        pv       <= 1'b0;
      end else if (scan_idx != (tws_pkg::SLOT_BITS + 1)'(tws_pkg::TIMER_SLOTS)) begin
        scan_idx <= scan_idx + (tws_pkg::SLOT_BITS + 1)'(1);
        pidx     <= scan_idx[tws_pkg::SLOT_BITS-1:0];
        pv       <= 1'b1;
      end else begin
        pv <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_tv     <= in_tv;
            req_tag    <= tag;
            req_notify <= !suppress_notify;
            req_id     <= cancel_id[tws_pkg::SLOT_BITS-1:0];
            hits       <= '0;
            found      <= 1'b0;
            exp_k      <= '0;
            fired      <= '0;
            unique case (cmd)
              tws_pkg::CMD_SCHEDULE: begin
                if (free_found) begin
                  active[free_idx] <= 1'b1;
                  res <= '{kind: tws_pkg::KIND_SCHEDULED,
                           id: tws_pkg::ID_BITS'(free_idx),
                           last: 1'b1, default: '0};
                end else begin
                  res <= '{kind: tws_pkg::KIND_FULL, last: 1'b1, default: '0};
                end
                state <= S_EMIT;
              end
              tws_pkg::CMD_CANCEL_ID: begin
                if (id_ok) begin
                  state <= S_CAN_RD;
                end else begin
                  res   <= '{kind: tws_pkg::KIND_NOT_FOUND, id: cancel_id,
                             last: 1'b1, default: '0};
                  state <= S_EMIT;
                end
              end
              tws_pkg::CMD_CANCEL_TAG: state <= S_TAG_SCAN;
              tws_pkg::CMD_EXPIRE:     state <= S_EXP_SCAN;
              default:                 state <= S_IDLE;
            endcase
          end
        end

        S_CAN_RD: begin
          active[req_id] <= 1'b0;
          res   <= '{kind: tws_pkg::KIND_CANCELLED, id: tws_pkg::ID_BITS'(req_id),
                     tag: rd_data.tag, ctx: rd_data.ctx,
                     count: tws_pkg::COUNT_BITS'(1), notify: req_notify, last: 1'b1};
          state <= S_EMIT;
        end

        S_TAG_SCAN: begin
          if (pv && active[pidx] && (rd_data.tag == req_tag)) begin
            active[pidx] <= 1'b0;
            hits         <= hits + tws_pkg::CNT_BITS'(1);
          end
          if (scan_done) begin
            res   <= '{kind: (hits != '0) ? tws_pkg::KIND_CANCELLED
                                          : tws_pkg::KIND_NOT_FOUND,
                       tag: req_tag, count: tws_pkg::COUNT_BITS'(hits),
                       notify: req_notify, last: 1'b1, default: '0};
            state <= S_EMIT;
          end
        end

        S_EXP_SCAN: begin
          if (cand) begin
            found    <= 1'b1;
            best_idx <= pidx;
            best_rec <= rd_data;
          end
          if (scan_done) begin
            if (found) begin
              fired[best_idx] <= 1'b1;
              exp_k           <= exp_k + tws_pkg::CNT_BITS'(1);
              res <= '{kind: tws_pkg::KIND_EXPIRED, id: tws_pkg::ID_BITS'(best_idx),
                       tag: best_rec.tag, ctx: best_rec.ctx, default: '0};
              if (best_rec.period == '0) begin
                active[best_idx] <= 1'b0;
                state            <= S_EMIT;
              end else begin
                state <= S_EXP_DIV;
              end
            end else begin
              res   <= '{kind: tws_pkg::KIND_DONE, count: tws_pkg::COUNT_BITS'(exp_k),
                         last: 1'b1, default: '0};
              state <= S_EMIT;
            end
          end
        end

        S_EXP_DIV: begin
          if (div_done) begin
            base  <= req_tv - div_rem;
            state <= S_EXP_WR;
          end
        end

        S_EXP_WR: begin
          // Drop a periodic timer whose next deadline runs past the time range
          if (next_sum[tws_pkg::TIME_BITS]) begin
            active[best_idx] <= 1'b0;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            if (res.last) begin
              state <= S_IDLE;
            end else begin
              found <= 1'b0;
              state <= S_EXP_SCAN;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_reg <= res;
    end
  end

  assign kind          = out_reg.kind;
  assign id_out        = out_reg.id;
  assign tag_out       = out_reg.tag;
  assign context_out   = out_reg.ctx;
  assign count         = out_reg.count;
  assign notify_cancel = out_reg.notify;
  assign last          = out_reg.last;

`ifndef NO_ASSERTIONS
  a_sched_fills_slot: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == tws_pkg::CMD_SCHEDULE) && free_found) |=>
      ($countones(active) == ($past($countones(active)) + 1)))
    else $error("schedule did not occupy exactly one slot");

  a_fired_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP_SCAN) |-> ($countones(fired) == 32'(exp_k)))
    else $error("fired flags disagree with expire count");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (best_rec.period != '0))
    else $error("remainder unit started with zero period");
`endif

endmodule
